>>> design/squ_pkg.sv
package squ_pkg;

  // Default build of the angle and trig formats
  localparam int ANGLE_BITS_DEF     = 12;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // Field widths
  localparam int SLOT_W  = 12;
  localparam int COORD_W = 20;
  localparam int EDGE_W  = 16;
  localparam int ROT_W   = 16;
  localparam int COLOR_W = 32;

  // Saturation bounds of a corner coordinate
  localparam int COORD_MAX = 524287;
  localparam int COORD_MIN = -524288;

  // Particle fields carried alongside the arithmetic
  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic [COLOR_W-1:0]        color;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [EDGE_W-1:0]         edge_size;
    logic signed [ROT_W-1:0]   rot;
  } side_t;

endpackage

>>> design/sprite_quad_corner_transform_unit.sv
// Rotated sprite quad corner generator. Each transaction in carries one
// particle (slot, centre, edge length, rotation, colour) and produces one
// transaction out with the four corners of its square plus slot and colour.
// It is a five-stage pipeline: input register, binary-angle quotient,
// trig ROM read, half-size multiplies, corner sums with round and saturate.
// One particle is taken every cycle unless an output stall has filled
// every stage; a stall at the output backs up stage by stage, so empty
// stages keep accepting. The trig ROM holds a quarter wave of
// 2^(ANGLE_BITS-2) entries built at elaboration; it needs no fill after
// reset.
module sprite_quad_corner_transform_unit #(
  parameter int ANGLE_BITS     = squ_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = squ_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [squ_pkg::SLOT_W-1:0]          slot_index_i,
  input  logic signed [squ_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [squ_pkg::COORD_W-1:0]  pos_y_i,
  input  logic [squ_pkg::EDGE_W-1:0]          edge_size_i,
  input  logic signed [squ_pkg::ROT_W-1:0]    rotation_deg_i,
  input  logic [squ_pkg::COLOR_W-1:0]         abgr_color_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [squ_pkg::SLOT_W-1:0]          slot_out_o,
  output logic signed [squ_pkg::COORD_W-1:0]  bl_x_o,
  output logic signed [squ_pkg::COORD_W-1:0]  bl_y_o,
  output logic signed [squ_pkg::COORD_W-1:0]  br_x_o,
  output logic signed [squ_pkg::COORD_W-1:0]  br_y_o,
  output logic signed [squ_pkg::COORD_W-1:0]  tl_x_o,
  output logic signed [squ_pkg::COORD_W-1:0]  tl_y_o,
  output logic signed [squ_pkg::COORD_W-1:0]  tr_x_o,
  output logic signed [squ_pkg::COORD_W-1:0]  tr_y_o,
  output logic [squ_pkg::COLOR_W-1:0]         color_out_o
);

  localparam int Stages = 5;

  logic [Stages-1:0]       valid_d, valid_q;
  logic [Stages-1:0]       ready;
  squ_pkg::side_t          side_q [Stages-1];
  squ_pkg::side_t          side_in;
  logic [ANGLE_BITS-1:0]   rom_addr;
  logic signed [TRIG_FRAC_BITS+1:0] sin_v;
  logic signed [TRIG_FRAC_BITS+1:0] cos_v;
  logic [squ_pkg::SLOT_W-1:0]  slot_q;
  logic [squ_pkg::COLOR_W-1:0] color_q;
  logic                        out_zero_q;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    ready[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  // Advance the valid bits
  always_comb begin
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < Stages; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign side_in.slot      = slot_index_i;
  assign side_in.color     = abgr_color_i;
  assign side_in.pos_x     = pos_x_i;
  assign side_in.pos_y     = pos_y_i;
  assign side_in.edge_size = edge_size_i;
  assign side_in.rot       = rotation_deg_i;

  // Carry the particle fields beside the arithmetic
  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      side_q[0] <= side_in;
    end
    for (int k = 1; k < Stages - 1; k++) begin
      if (ready[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
    if (ready[Stages-1]) begin
      slot_q     <= side_q[Stages-2].slot;
      color_q    <= side_q[Stages-2].color;
      out_zero_q <= (side_q[Stages-2].rot == '0);
    end
  end

  squ_angle #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_angle (
    .clk_i  (clk_i),
    .en_i   (ready[1]),
    .rot_i  (side_q[0].rot),
    .addr_o (rom_addr)
  );

  squ_trig_rom #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk_i  (clk_i),
    .en_i   (ready[2]),
    .addr_i (rom_addr),
    .sin_o  (sin_v),
    .cos_o  (cos_v)
  );

  squ_corner #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_corner (
    .clk_i    (clk_i),
    .en_mul_i (ready[3]),
    .en_out_i (ready[4]),
    .zero_i   (side_q[2].rot == '0),
    .edge_i   (side_q[2].edge_size),
    .sin_i    (sin_v),
    .cos_i    (cos_v),
    .pos_x_i  (side_q[3].pos_x),
    .pos_y_i  (side_q[3].pos_y),
    .bl_x_o   (bl_x_o),
    .bl_y_o   (bl_y_o),
    .br_x_o   (br_x_o),
    .br_y_o   (br_y_o),
    .tl_x_o   (tl_x_o),
    .tl_y_o   (tl_y_o),
    .tr_x_o   (tr_x_o),
    .tr_y_o   (tr_y_o)
  );

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[Stages-1];
  assign slot_out_o  = slot_q;
  assign color_out_o = color_q;

  // Input stalls only when every stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled with an empty pipeline stage");

  // A result only appears from a filled previous stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[Stages-2]))
    else $error("result valid without a preceding stage");

  // An unrotated quad is axis aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_zero_q) |->
      (bl_x_o == tl_x_o && br_x_o == tr_x_o && bl_y_o == br_y_o && tl_y_o == tr_y_o))
    else $error("unrotated quad corners not axis aligned");

endmodule

>>> design/squ_angle.sv
// Degrees to negated binary angle: floor((deg * 2^(AB+1) + 23040) / 46080),
// then negate and wrap to ANGLE_BITS. The divide by 46080 is a shift by 10
// and a reciprocal multiply by 1/45 with one correction step.
module squ_angle #(
  parameter int ANGLE_BITS = squ_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [squ_pkg::ROT_W-1:0]      rot_i,
  output logic [ANGLE_BITS-1:0]                 addr_o
);

  localparam int MW = ANGLE_BITS + 18;
  localparam int VW = MW - 10;
  localparam int RW = VW - 5;
  localparam longint unsigned RecipL = (64'd1 << VW) / 45;
  localparam longint unsigned Koff   = ((64'd1 << (ANGLE_BITS + 16)) / 46080) + 1;
  localparam logic [RW-1:0]         Recip    = RW'(RecipL);
  localparam logic [MW-1:0]         OffsetM  = MW'(Koff * 64'd46080);
  localparam logic [MW-1:0]         HalfTurn = MW'(23040);
  localparam logic [ANGLE_BITS-1:0] KoffLow  = ANGLE_BITS'(Koff);
  localparam logic [VW-1:0]         Div45    = VW'(45);

  logic signed [MW-1:0] deg_ext;
  logic [MW-1:0]        num;
  logic [VW-1:0]        v_d, v_q;
  logic [VW+RW-1:0]     prod;
  logic [RW-1:0]        q0_d, q0_q;
  logic [VW-1:0]        q0_x45;
  logic [VW-1:0]        rem;
  logic [RW-1:0]        quo;

  // Offset numerator so it stays positive, drop the power of two
  assign deg_ext = MW'(rot_i);
  assign num     = (deg_ext <<< (ANGLE_BITS + 1)) + HalfTurn + OffsetM;
  assign v_d     = num[MW-1:10];
  assign prod    = v_d * Recip;
  assign q0_d    = prod[VW+RW-1:VW];

  // Hold the quotient estimate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q  <= v_d;
      q0_q <= q0_d;
    end
  end

  // Correct the estimate by one, remove the offset and negate
  assign q0_x45 = (VW'(q0_q) << 5) + (VW'(q0_q) << 3) + (VW'(q0_q) << 2) + VW'(q0_q);
  assign rem    = v_q - q0_x45;
  assign quo    = (rem >= Div45) ? q0_q + RW'(1) : q0_q;
  assign addr_o = KoffLow - quo[ANGLE_BITS-1:0];

endmodule

>>> design/squ_trig_rom.sv
// Quarter-wave sine/cosine ROM with registered read and quadrant folding.
module squ_trig_rom #(
  parameter int ANGLE_BITS     = squ_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = squ_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [ANGLE_BITS-1:0]           addr_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);

  localparam int TF          = TRIG_FRAC_BITS;
  localparam int Depth       = 1 << (ANGLE_BITS - 2);
  localparam int SeriesTerms = 12;
  localparam logic [63:0] PiQ30 = 64'd3373259426;
  localparam logic [63:0] OneQ30 = 64'd1 << 30;
  localparam logic [63:0] SinDiv [SeriesTerms] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
  localparam logic [63:0] CosDiv [SeriesTerms] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

  typedef logic [2*(TF+1)-1:0] rom_word_t;
  typedef rom_word_t rom_arr_t [Depth];

  // Clamp a Q30 value to [0, 1] and round it to the trig format
  function automatic logic [TF:0] to_trig(logic signed [63:0] val);
    logic [63:0] u;
    if (val < 0) begin
      u = 64'd0;
    end else if (val > $signed(OneQ30)) begin
      u = OneQ30;
    end else begin
      u = val;
    end
    u = u + (64'd1 << (29 - TF));
    return (TF+1)'(u >> (30 - TF));
  endfunction

  // Taylor series for one quarter turn, worked out at elaboration
  function automatic rom_arr_t build_rom();
    rom_arr_t          rom;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       t;
    logic signed [63:0] ssum;
    logic signed [63:0] csum;
    for (int k = 0; k < Depth; k++) begin
      x  = (64'(k) * PiQ30 * 64'd2 + (64'd1 << (ANGLE_BITS - 1))) >> ANGLE_BITS;
      x2 = (x * x) >> 30;
      t    = x;
      ssum = $signed(t);
      for (int n = 0; n < SeriesTerms; n++) begin
        t = ((t * x2) >> 30) / SinDiv[n];
        if ((n & 1) == 0) begin
          ssum = ssum - $signed(t);
        end else begin
          ssum = ssum + $signed(t);
        end
      end
      t    = OneQ30;
      csum = $signed(t);
      for (int n = 0; n < SeriesTerms; n++) begin
        t = ((t * x2) >> 30) / CosDiv[n];
        if ((n & 1) == 0) begin
          csum = csum - $signed(t);
        end else begin
          csum = csum + $signed(t);
        end
      end
      rom[k] = {to_trig(ssum), to_trig(csum)};
    end
    return rom;
  endfunction

  localparam rom_arr_t Rom = build_rom();

  rom_word_t  word_q;
  logic [1:0] quad_q;
  logic signed [TF+1:0] s_ext;
  logic signed [TF+1:0] c_ext;

  // Read the quarter table and hold the quadrant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= Rom[addr_i[ANGLE_BITS-3:0]];
      quad_q <= addr_i[ANGLE_BITS-1:ANGLE_BITS-2];
    end
  end

  assign s_ext = $signed({1'b0, word_q[2*(TF+1)-1:TF+1]});
  assign c_ext = $signed({1'b0, word_q[TF:0]});

  // Fold the quadrant into sign and swap
  always_comb begin
    case (quad_q)
      2'd0: begin
        sin_o = s_ext;
        cos_o = c_ext;
      end
      2'd1: begin
        sin_o = c_ext;
        cos_o = -s_ext;
      end
      2'd2: begin
        sin_o = -s_ext;
        cos_o = -c_ext;
      end
      default: begin
        sin_o = -c_ext;
        cos_o = s_ext;
      end
    endcase
  end

endmodule

>>> design/squ_corner.sv
// Half-size products, then corner sums with rounding and saturation.
module squ_corner #(
  parameter int TRIG_FRAC_BITS = squ_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    en_mul_i,
  input  logic                                    en_out_i,
  input  logic                                    zero_i,
  input  logic [squ_pkg::EDGE_W-1:0]              edge_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]        sin_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]        cos_i,
  input  logic signed [squ_pkg::COORD_W-1:0]      pos_x_i,
  input  logic signed [squ_pkg::COORD_W-1:0]      pos_y_i,
  output logic signed [squ_pkg::COORD_W-1:0]      bl_x_o,
  output logic signed [squ_pkg::COORD_W-1:0]      bl_y_o,
  output logic signed [squ_pkg::COORD_W-1:0]      br_x_o,
  output logic signed [squ_pkg::COORD_W-1:0]      br_y_o,
  output logic signed [squ_pkg::COORD_W-1:0]      tl_x_o,
  output logic signed [squ_pkg::COORD_W-1:0]      tl_y_o,
  output logic signed [squ_pkg::COORD_W-1:0]      tr_x_o,
  output logic signed [squ_pkg::COORD_W-1:0]      tr_y_o
);

  localparam int TF   = TRIG_FRAC_BITS;
  localparam int CW   = squ_pkg::COORD_W;
  localparam int SW   = TF + 23;
  localparam int MulW = TF + squ_pkg::EDGE_W + 3;
  localparam int RW   = SW - TF - 1;
  localparam logic signed [SW-1:0] Half = SW'(1) <<< TF;
  localparam logic signed [RW-1:0] RMax = RW'(squ_pkg::COORD_MAX);
  localparam logic signed [RW-1:0] RMin = RW'(squ_pkg::COORD_MIN);

  // Round half up, drop the extra fraction bits and saturate
  function automatic logic signed [CW-1:0] finish(logic signed [SW-1:0] val);
    logic signed [SW-1:0] t;
    logic signed [RW-1:0] r;
    t = val + Half;
    r = $signed(t[SW-1:TF+1]);
    if (r > RMax) begin
      r = RMax;
    end else if (r < RMin) begin
      r = RMin;
    end
    return CW'(r);
  endfunction

  logic signed [squ_pkg::EDGE_W:0] edge_ext;
  logic signed [MulW-1:0] c_mul;
  logic signed [MulW-1:0] s_mul;
  logic signed [SW-1:0]   hh;
  logic signed [SW-1:0]   c_d, c_q;
  logic signed [SW-1:0]   s_d, s_q;
  logic signed [SW-1:0]   cy_d, cy_q;
  logic signed [SW-1:0]   px;
  logic signed [SW-1:0]   py;

  // Form h*cos and h*sin; zero rotation takes the flat half-size
  assign edge_ext = $signed({1'b0, edge_i});
  assign c_mul    = edge_ext * cos_i;
  assign s_mul    = edge_ext * sin_i;
  assign hh       = SW'(edge_ext) <<< TF;
  assign c_d      = zero_i ? hh : SW'(c_mul);
  assign s_d      = zero_i ? '0 : SW'(s_mul);
  // The unrotated form has its y sense flipped
  assign cy_d     = zero_i ? -hh : SW'(c_mul);

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      c_q  <= c_d;
      s_q  <= s_d;
      cy_q <= cy_d;
    end
  end

  assign px = SW'(pos_x_i) <<< (TF + 1);
  assign py = SW'(pos_y_i) <<< (TF + 1);

  // Sum each corner and register the result
  always_ff @(posedge clk_i) begin
    if (en_out_i) begin
      bl_x_o <= finish(px - c_q + s_q);
      bl_y_o <= finish(py - s_q - cy_q);
      br_x_o <= finish(px + c_q + s_q);
      br_y_o <= finish(py + s_q - cy_q);
      tl_x_o <= finish(px - c_q - s_q);
      tl_y_o <= finish(py - s_q + cy_q);
      tr_x_o <= finish(px + c_q - s_q);
      tr_y_o <= finish(py + s_q + cy_q);
    end
  end

endmodule

>>> dv/sprite_quad_corner_transform_unit_tb.sv
module sprite_quad_corner_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_BITS     = squ_pkg::ANGLE_BITS_DEF;
  localparam int TRIG_FRAC_BITS = squ_pkg::TRIG_FRAC_BITS_DEF;
  localparam int SLOT_W         = squ_pkg::SLOT_W;
  localparam int COORD_W        = squ_pkg::COORD_W;
  localparam int EDGE_W         = squ_pkg::EDGE_W;
  localparam int ROT_W          = squ_pkg::ROT_W;
  localparam int COLOR_W        = squ_pkg::COLOR_W;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30         = 64'sd1 <<< 30;
  localparam longint DEG_PER_TURN    = 64'sd23040;
  localparam int SERIES_TERMS        = 12;
  localparam int MAX_WAIT            = 18;
  localparam int RANDOM_ITEMS        = 1500;
  localparam int DRAIN_CYCLES        = 20;
  localparam int CYCLE_LIMIT         = 400000;

  // Pacing styles for either side of the block
  typedef enum int {
    PACE_NONE,
    PACE_FULL,
    PACE_LIGHT
  } pace_e;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] bl_x;
    logic signed [COORD_W-1:0] bl_y;
    logic signed [COORD_W-1:0] br_x;
    logic signed [COORD_W-1:0] br_y;
    logic signed [COORD_W-1:0] tl_x;
    logic signed [COORD_W-1:0] tl_y;
    logic signed [COORD_W-1:0] tr_x;
    logic signed [COORD_W-1:0] tr_y;
    logic [COLOR_W-1:0]        color;
  } quad_t;

  // Predict the corner quad of each accepted particle and check results in order
  class quad_board;
    quad_t expected_q[$];
    int    fail_count;

    function new();
      fail_count = 0;
    endfunction

    task report(input string msg);
      $display("%s", msg);
      fail_count++;
    endtask

    // Clamp a Q30 series sum to [0, 1] and round it to the trig format
    function longint trig_round(input longint v);
      if (v < 0) v = 0;
      if (v > ONE_Q30) v = ONE_Q30;
      return (v + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    endfunction

    // Sine and cosine of one binary angle, Taylor series per quadrant
    function void trig_lookup(input logic [ANGLE_BITS-1:0] addr,
                              output longint sn, output longint cs);
      longint unsigned kk, x, x2, t, full;
      longint ssum, csum, s, c;
      logic [1:0] quad;
      int n;
      full = 64'd1 << ANGLE_BITS;
      quad = addr[ANGLE_BITS-1 -: 2];
      kk   = longint'(addr[ANGLE_BITS-3:0]);
      x    = (kk * PI_Q30 * 64'd2 + (full >> 1)) >> ANGLE_BITS;
      x2   = (x * x) >> 30;
      t    = x;
      ssum = longint'(t);
      for (n = 1; n <= SERIES_TERMS; n++) begin
        t = ((t * x2) >> 30) / (2 * n * (2 * n + 1));
        if (n % 2 == 1) ssum -= longint'(t);
        else ssum += longint'(t);
      end
      t    = 64'd1 << 30;
      csum = longint'(t);
      for (n = 1; n <= SERIES_TERMS; n++) begin
        t = ((t * x2) >> 30) / ((2 * n - 1) * (2 * n));
        if (n % 2 == 1) csum -= longint'(t);
        else csum += longint'(t);
      end
      s = trig_round(ssum);
      c = trig_round(csum);
      case (quad)
        2'd0: begin sn = s;  cs = c;  end
        2'd1: begin sn = c;  cs = -s; end
        2'd2: begin sn = -s; cs = -c; end
        default: begin sn = -c; cs = s; end
      endcase
    endfunction

    // Degrees to binary angle, rounded half up, then negated and wrapped
    function logic [ANGLE_BITS-1:0] rom_address(input logic signed [ROT_W-1:0] deg);
      longint off, num, b;
      off = 64'sd1 <<< 34;
      num = 2 * longint'(deg) * (64'sd1 <<< ANGLE_BITS) + DEG_PER_TURN
            + 2 * DEG_PER_TURN * off;
      b = num / (2 * DEG_PER_TURN) - off;
      return ANGLE_BITS'(-b);
    endfunction

    // Round an exact corner sum to the coordinate format and saturate
    function logic signed [COORD_W-1:0] round_sat(input longint v);
      longint r;
      r = (v + (64'sd1 <<< TRIG_FRAC_BITS)) >>> (1 + TRIG_FRAC_BITS);
      if (r > squ_pkg::COORD_MAX) r = squ_pkg::COORD_MAX;
      if (r < squ_pkg::COORD_MIN) r = squ_pkg::COORD_MIN;
      return COORD_W'(r);
    endfunction

    function quad_t compute_quad_corners(input squ_pkg::side_t p);
      quad_t  q;
      longint px, py, h, hh, sn, cs, c, s;
      px = longint'($signed(p.pos_x)) * (64'sd1 <<< (1 + TRIG_FRAC_BITS));
      py = longint'($signed(p.pos_y)) * (64'sd1 <<< (1 + TRIG_FRAC_BITS));
      h  = longint'(p.edge_size);
      q.slot  = p.slot;
      q.color = p.color;
      if (p.rot == '0) begin
        // Axis-aligned corners, y sense flipped against the rotated form
        hh = h * (64'sd1 <<< TRIG_FRAC_BITS);
        q.bl_x = round_sat(px - hh); q.bl_y = round_sat(py + hh);
        q.br_x = round_sat(px + hh); q.br_y = round_sat(py + hh);
        q.tl_x = round_sat(px - hh); q.tl_y = round_sat(py - hh);
        q.tr_x = round_sat(px + hh); q.tr_y = round_sat(py - hh);
      end else begin
        trig_lookup(rom_address(p.rot), sn, cs);
        c = h * cs;
        s = h * sn;
        q.bl_x = round_sat(px - c + s); q.bl_y = round_sat(py - s - c);
        q.br_x = round_sat(px + c + s); q.br_y = round_sat(py + s - c);
        q.tl_x = round_sat(px - c - s); q.tl_y = round_sat(py - s + c);
        q.tr_x = round_sat(px + c - s); q.tr_y = round_sat(py + s + c);
      end
      return q;
    endfunction

    function void note_particle(input squ_pkg::side_t p);
      expected_q.push_back(compute_quad_corners(p));
    endfunction

    task compare_field(input string name, input logic [SLOT_W-1:0] slot,
                       input logic signed [63:0] got, input logic signed [63:0] want);
      if (got !== want)
        report($sformatf("MISMATCH slot %0d %s: got %0d expected %0d",
                         slot, name, got, want));
    endtask

    task check_quad(input quad_t got);
      quad_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("UNEXPECTED result for slot %0d with no particle pending",
                         got.slot));
        return;
      end
      want = expected_q.pop_front();
      compare_field("slot_out",  want.slot, got.slot,  want.slot);
      compare_field("bl_x",      want.slot, got.bl_x,  want.bl_x);
      compare_field("bl_y",      want.slot, got.bl_y,  want.bl_y);
      compare_field("br_x",      want.slot, got.br_x,  want.br_x);
      compare_field("br_y",      want.slot, got.br_y,  want.br_y);
      compare_field("tl_x",      want.slot, got.tl_x,  want.tl_x);
      compare_field("tl_y",      want.slot, got.tl_y,  want.tl_y);
      compare_field("tr_x",      want.slot, got.tr_x,  want.tr_x);
      compare_field("tr_y",      want.slot, got.tr_y,  want.tr_y);
      compare_field("color_out", want.slot, got.color, want.color);
    endtask
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [SLOT_W-1:0]         slot_index_i;
  logic signed [COORD_W-1:0] pos_x_i;
  logic signed [COORD_W-1:0] pos_y_i;
  logic [EDGE_W-1:0]         edge_size_i;
  logic signed [ROT_W-1:0]   rotation_deg_i;
  logic [COLOR_W-1:0]        abgr_color_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [SLOT_W-1:0]         slot_out_o;
  logic signed [COORD_W-1:0] bl_x_o;
  logic signed [COORD_W-1:0] bl_y_o;
  logic signed [COORD_W-1:0] br_x_o;
  logic signed [COORD_W-1:0] br_y_o;
  logic signed [COORD_W-1:0] tl_x_o;
  logic signed [COORD_W-1:0] tl_y_o;
  logic signed [COORD_W-1:0] tr_x_o;
  logic signed [COORD_W-1:0] tr_y_o;
  logic [COLOR_W-1:0]        color_out_o;

  quad_board board;
  pace_e     send_pace = PACE_FULL;
  pace_e     recv_pace = PACE_FULL;
  int        sent_count = 0;
  int        seen_count = 0;
  int        cycle_count = 0;

  sprite_quad_corner_transform_unit #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .slot_index_i  (slot_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .edge_size_i   (edge_size_i),
    .rotation_deg_i(rotation_deg_i),
    .abgr_color_i  (abgr_color_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_out_o    (slot_out_o),
    .bl_x_o        (bl_x_o),
    .bl_y_o        (bl_y_o),
    .br_x_o        (br_x_o),
    .br_y_o        (br_y_o),
    .tl_x_o        (tl_x_o),
    .tl_y_o        (tl_y_o),
    .tr_x_o        (tr_x_o),
    .tr_y_o        (tr_y_o),
    .color_out_o   (color_out_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Bound the run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_wait(input pace_e pace);
    case (pace)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(MAX_WAIT);
      default:   return ($urandom_range(3) == 0) ? $urandom_range(MAX_WAIT) : 0;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] draw_coord();
    case ($urandom_range(9))
      0:       return COORD_W'(squ_pkg::COORD_MAX - int'($urandom_range(4096)));
      1:       return COORD_W'(squ_pkg::COORD_MIN + int'($urandom_range(4096)));
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic squ_pkg::side_t random_particle();
    squ_pkg::side_t p;
    int r;
    p.slot  = SLOT_W'($urandom_range(4095));
    p.color = $urandom();
    p.pos_x = draw_coord();
    p.pos_y = draw_coord();
    case ($urandom_range(7))
      0:       p.edge_size = EDGE_W'(65535 - $urandom_range(255));
      1:       p.edge_size = EDGE_W'($urandom_range(64));
      default: p.edge_size = EDGE_W'($urandom_range(65535));
    endcase
    // Mostly full-range turns, with zero, tiny and extreme rotations mixed in
    case ($urandom_range(19))
      0, 1:    r = 0;
      2:       r = int'($urandom_range(4)) - 2;
      3:       r = ($urandom_range(1) == 1) ? 23039 - int'($urandom_range(64))
                                            : -23040 + int'($urandom_range(64));
      default: r = int'($urandom_range(46079)) - 23040;
    endcase
    p.rot = ROT_W'(r);
    return p;
  endfunction

  // Drive one particle transaction and hold it until accepted
  task automatic send_particle(input squ_pkg::side_t p);
    int gap;
    gap = draw_wait(send_pace);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    slot_index_i   = p.slot;
    pos_x_i        = p.pos_x;
    pos_y_i        = p.pos_y;
    edge_size_i    = p.edge_size;
    rotation_deg_i = p.rot;
    abgr_color_i   = p.color;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_particle(p);
    sent_count++;
    if (sent_count % 50 == 0) send_pace = pace_e'($urandom_range(2));
    @(negedge clk_i);
  endtask

  task automatic send_directed(input int slot, input int x, input int y, input int edge_len,
                               input int rot, input logic [COLOR_W-1:0] color);
    squ_pkg::side_t p;
    p.slot      = SLOT_W'(slot);
    p.pos_x     = COORD_W'(x);
    p.pos_y     = COORD_W'(y);
    p.edge_size = EDGE_W'(edge_len);
    p.rot       = ROT_W'(rot);
    p.color     = color;
    send_particle(p);
  endtask

  // Accept and check result transactions with random stalls
  initial begin
    int stall;
    quad_t got;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(recv_pace);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.slot  = slot_out_o;
      got.bl_x  = bl_x_o;
      got.bl_y  = bl_y_o;
      got.br_x  = br_x_o;
      got.br_y  = br_y_o;
      got.tl_x  = tl_x_o;
      got.tl_y  = tl_y_o;
      got.tr_x  = tr_x_o;
      got.tr_y  = tr_y_o;
      got.color = color_out_o;
      board.check_quad(got);
      seen_count++;
      if (seen_count % 64 == 0) recv_pace = pace_e'($urandom_range(2));
      @(negedge clk_i);
    end
  end

  initial begin
    board          = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    slot_index_i   = '0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    edge_size_i    = '0;
    rotation_deg_i = '0;
    abgr_color_i   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Unrotated squares, including degenerate and saturating ones
    send_directed(0, 0, 0, 0, 0, 32'h0000_0000);
    send_directed(4095, 100, -200, 160, 0, 32'hFFFF_FFFF);
    send_directed(1, 5, -7, 1, 0, 32'h8040_2010);
    send_directed(2, squ_pkg::COORD_MAX, squ_pkg::COORD_MAX, 65535, 0, 32'h1234_5678);
    send_directed(3, squ_pkg::COORD_MIN, squ_pkg::COORD_MIN, 65535, 0, 32'hFF00_FF00);
    // Tiny rotations whose binary angle rounds to zero stay on the rotated path
    send_directed(4, 320, 480, 256, 1, 32'h00FF_00FF);
    send_directed(5, -320, 480, 256, -2, 32'hA5A5_A5A5);
    // Quadrant boundaries and diagonals
    send_directed(6, 1000, 1000, 320, 2880, 32'h5A5A_5A5A);
    send_directed(7, 1000, -1000, 320, 5760, 32'h0F0F_0F0F);
    send_directed(8, -1000, 1000, 320, 11520, 32'hF0F0_F0F0);
    send_directed(9, 0, 0, 320, 17280, 32'h0102_0304);
    send_directed(10, 0, 0, 320, -5760, 32'h0506_0708);
    send_directed(11, 0, 0, 320, -11520, 32'h090A_0B0C);
    send_directed(12, 0, 0, 1001, 64, 32'h0D0E_0F10);
    send_directed(13, 0, 0, 1001, -64, 32'h1112_1314);
    // Turn extremes, the top one wrapping back to zero
    send_directed(14, 777, -777, 4096, -23040, 32'hDEAD_BEEF);
    send_directed(15, 777, -777, 4096, 23039, 32'hCAFE_F00D);
    // Rotated corners pushed past the coordinate range
    send_directed(16, squ_pkg::COORD_MAX, squ_pkg::COORD_MIN, 65535, 2880, 32'h7777_7777);
    send_directed(17, squ_pkg::COORD_MIN, squ_pkg::COORD_MAX, 65535, -8640, 32'h8888_8888);
    send_directed(18, squ_pkg::COORD_MAX, squ_pkg::COORD_MAX, 65535, 1, 32'h0000_0001);
    send_directed(19, 12, 34, 1, 5760, 32'h8000_0000);

    repeat (RANDOM_ITEMS) send_particle(random_particle());
    in_valid_i = 1'b0;

    // Drain, then keep watching for stray results before the verdict
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sprite_quad_corner_transform_unit.f
design/squ_pkg.sv
design/squ_angle.sv
design/squ_trig_rom.sv
design/squ_corner.sv
design/sprite_quad_corner_transform_unit.sv
dv/sprite_quad_corner_transform_unit_tb.sv
